[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define ADRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adrs check failed");

// Next-cycle implication, sampled on the rising edge, off during reset
`define ADRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adrs check failed");

`endif

[rtl/core/adrs_pkg.sv]
// ---------------------------------------------------------------------------
// adrs_pkg
// Shared constants and controller/datapath interface types for the
// alternating direction row sorter.
// ---------------------------------------------------------------------------
package adrs_pkg;

  // Default row store depth
  localparam int MAX_COLS_DEF = 16;

  // Element width, fixed by the data format
  localparam int ELEM_W = 32;
  localparam int ROW_W  = 16;

  // Commands from controller to datapath
  typedef struct packed {
    logic insert;      // place an accepted element in the sorted store
    logic emit_start;  // load the first result of the row
    logic emit_next;   // load the following result
    logic clear;       // empty the store after the last result
  } adrs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_last;    // result register holds the row's final element
  } adrs_status_t;

endpackage

[rtl/core/adrs_datapath.sv]
// ---------------------------------------------------------------------------
// adrs_datapath
// Insertion chain holding the current row in ascending order, fill count,
// row direction and the result register with its read pointer.
// ---------------------------------------------------------------------------
module adrs_datapath #(
  parameter int MAX_COLS = adrs_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  adrs_pkg::adrs_cmd_t               cmd,
  output adrs_pkg::adrs_status_t            status,
  input  logic signed [adrs_pkg::ELEM_W-1:0] element_value,
  input  logic        [adrs_pkg::ROW_W-1:0]  row_number,
  output logic signed [adrs_pkg::ELEM_W-1:0] sorted_value,
  output logic                              row_done
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int PTR_W = $clog2(MAX_COLS);

  logic signed [adrs_pkg::ELEM_W-1:0] cells      [MAX_COLS];
  logic signed [adrs_pkg::ELEM_W-1:0] cells_next [MAX_COLS];
  logic        [MAX_COLS-1:0]         gt;
  logic        [CNT_W-1:0]            fill_count;
  logic                               row_descending;
  logic        [PTR_W-1:0]            ptr;
  logic        [PTR_W-1:0]            first;
  logic        [CNT_W-1:0]            left;
  logic                               full;

  assign full = (fill_count == CNT_W'(MAX_COLS));

  // Per-cell compare: empty cells count as larger than anything
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      gt[i] = (CNT_W'(i) >= fill_count) || (cells[i] > element_value);
    end
  end

  // Shift-up insertion: cells above the insertion point move up one place
  always_comb begin
    cells_next[0] = gt[0] ? element_value : cells[0];
    for (int i = 1; i < MAX_COLS; i++) begin
      if (!gt[i]) begin
        cells_next[i] = cells[i];
      end else if (!gt[i-1]) begin
        cells_next[i] = element_value;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  // First read place: top of the store for descending rows
  assign first = row_descending ? PTR_W'(fill_count - CNT_W'(1)) : '0;

  // Row store, written only while it has room
  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  // Fill count and direction
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      row_descending <= 1'b0;
    end else begin
      if (cmd.insert) begin
        row_descending <= ~row_number[0];
        if (!full) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (cmd.clear) begin
        fill_count <= '0;
      end
    end
  end

  // Result register and read pointer
  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      sorted_value <= cells[first];
      row_done     <= (fill_count == CNT_W'(1));
      left         <= fill_count - CNT_W'(1);
      ptr          <= row_descending ? (first - PTR_W'(1)) : (first + PTR_W'(1));
    end else if (cmd.emit_next) begin
      sorted_value <= cells[ptr];
      row_done     <= (left == CNT_W'(1));
      left         <= left - CNT_W'(1);
      ptr          <= row_descending ? (ptr - PTR_W'(1)) : (ptr + PTR_W'(1));
    end
  end

  assign status.out_last = row_done;

endmodule

[rtl/core/adrs_ctrl.sv]
// ---------------------------------------------------------------------------
// adrs_ctrl
// Sequencer: loads elements, prepares the first result on row end, then
// steps the datapath through the row one beat at a time.
// ---------------------------------------------------------------------------
module adrs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   row_end,
  output logic                   result_valid,
  input  logic                   result_ready,
  output adrs_pkg::adrs_cmd_t    cmd,
  input  adrs_pkg::adrs_status_t status
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t state;
  logic   item_beat;
  logic   result_beat;

  assign item_beat   = item_valid && item_ready;
  assign result_beat = result_valid && result_ready;

  // Commands to the datapath
  assign cmd.insert     = item_beat;
  assign cmd.emit_start = (state == ST_PREP);
  assign cmd.emit_next  = result_beat && !status.out_last;
  assign cmd.clear      = result_beat && status.out_last;

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      item_ready   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (item_beat && row_end) begin
            state      <= ST_PREP;
            item_ready <= 1'b0;
          end
        end
        ST_PREP: begin
          state        <= ST_EMIT;
          result_valid <= 1'b1;
        end
        ST_EMIT: begin
          if (result_beat && status.out_last) begin
            state        <= ST_LOAD;
            result_valid <= 1'b0;
            item_ready   <= 1'b1;
          end
        end
        default: begin
          state        <= ST_LOAD;
          item_ready   <= 1'b1;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/core/alternating_direction_row_sorter_core.sv]
// ---------------------------------------------------------------------------
// alternating_direction_row_sorter_core
// Buffers one matrix row, sorts it and emits it in snake order.
// ---------------------------------------------------------------------------
// Elements of a row are accepted one beat per cycle; each is dropped into
// place by a parallel insertion chain, so the store is always in ascending
// order. Elements beyond MAX_COLS are dropped. After the beat carrying
// row_end, a prepare state loads the result register, after which the row
// comes out one beat per cycle while result_ready is high: ascending for an
// odd row_number on the row_end beat, descending for an even one, with
// row_done on the final beat. item_ready is low from the row_end beat until
// the final result beat is taken, so a row passes in through the insertion
// chain, then the prepare state, and out through the single result register
// before the next row is taken.
module alternating_direction_row_sorter_core #(
  parameter int MAX_COLS = adrs_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic signed [adrs_pkg::ELEM_W-1:0] element_value,
  input  logic        [adrs_pkg::ROW_W-1:0]  row_number,
  input  logic                               row_end,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [adrs_pkg::ELEM_W-1:0] sorted_value,
  output logic                               row_done
);

  adrs_pkg::adrs_cmd_t    cmd;
  adrs_pkg::adrs_status_t status;

  // Sequencer
  adrs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .row_end      (row_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Store, sort and result register
  adrs_datapath #(
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .element_value (element_value),
    .row_number    (row_number),
    .sorted_value  (sorted_value),
    .row_done      (row_done)
  );

endmodule

[rtl/core/adrs_checker.sv]
// ---------------------------------------------------------------------------
// adrs_checker
// Port-level checks on the row sorter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adrs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        row_end,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [adrs_pkg::ELEM_W-1:0] sorted_value,
  input logic                        row_done
);

  logic                      item_beat;
  logic                      result_beat;
  logic                      result_stall;
  logic [adrs_pkg::ELEM_W:0] result_word;

  assign item_beat    = item_valid && item_ready;
  assign result_beat  = result_valid && result_ready;
  assign result_stall = result_valid && !result_ready;
  assign result_word  = {sorted_value, row_done};

  // A stalled result beat holds
  `ADRS_ASSERT_NEXT(a_result_hold, clk, rst, result_stall, result_valid && $stable(result_word))

  // No elements taken while a row is being emitted
  `ADRS_ASSERT_NOW(a_no_load_in_emit, clk, rst, result_valid, !item_ready)

  // Row end closes the input side
  `ADRS_ASSERT_NEXT(a_row_end_stops, clk, rst, item_beat && row_end, !item_ready)

  // Results keep coming until the marked beat
  `ADRS_ASSERT_NEXT(a_row_continues, clk, rst, result_beat && !row_done, result_valid)

  // Marked beat ends the row
  `ADRS_ASSERT_NEXT(a_row_ends, clk, rst, result_beat && row_done, !result_valid)

endmodule

bind alternating_direction_row_sorter_core adrs_checker u_adrs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .row_end      (row_end),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .sorted_value (sorted_value),
  .row_done     (row_done)
);
